@@ rtl/slid_pkg.sv @@
`default_nettype none
package slid_pkg;

    // Field widths of the item formats
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // Default number of entries the list holds
    localparam int unsigned CAPACITY_DEF = 16;

    // Operation codes (input tuser)
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    // Control broadcast to every cell
    typedef struct packed {
        logic cmp_en;     // capture compare flags against the key
        logic apply_ins;  // open a gap at the insert point and drop the key in
        logic apply_del;  // close the gap at the first matching entry
    } t_cell_ctrl;

endpackage
`default_nettype wire

@@ rtl/slid_cell.sv @@
`default_nettype none
module slid_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5
) (
    input  wire                                 i_clk,
    input  wire slid_pkg::t_cell_ctrl           i_ctrl,
    input  wire        [slid_pkg::VALUE_W-1:0]  i_key,
    input  wire        [CNT_W-1:0]              i_count,
    input  wire        [slid_pkg::VALUE_W-1:0]  i_left_entry,
    input  wire                                 i_left_lt,
    input  wire        [slid_pkg::VALUE_W-1:0]  i_right_entry,
    output logic       [slid_pkg::VALUE_W-1:0]  o_entry,
    output logic                                o_lt,
    output logic                                o_hit
);

    logic [slid_pkg::VALUE_W-1:0] r_entry;
    logic                         r_lt;
    logic                         r_eq;
    logic                         w_valid;

    // Slot holds a live entry when it lies below the count
    assign w_valid = (CNT_W'(IDX) < i_count);

    // Capture compare flags for the current key
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_lt <= w_valid && ($signed(r_entry) < $signed(i_key));
            r_eq <= w_valid && (r_entry == i_key);
        end
    end

    // Shift entries at and above the boundary
    always_ff @(posedge i_clk) begin
        if (i_ctrl.apply_ins && !r_lt) begin
            if (i_left_lt) begin
                r_entry <= i_key;
            end else begin
                r_entry <= i_left_entry;
            end
        end else if (i_ctrl.apply_del && !r_lt) begin
            r_entry <= i_right_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    // First entry not below the key and equal to it
    assign o_hit   = r_eq && i_left_lt;

endmodule
`default_nettype wire

@@ rtl/sorted_list_insert_delete_core.sv @@
// Each item passes a compare step (S_CMP), then a shift step (S_APPLY) that registers the result.
// The compare and shift steps of the cell chain run back to back, and the next key
// is captured during the shift step.
// A stalled result holds the chain in its shift step until taken.
// Reset (synchronous, active low) empties the list; stored entries keep no reset.
`default_nettype none
module sorted_list_insert_delete_core #(
    parameter int unsigned CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire  [0:0]  i_s_axis_tuser,   // [0] mode
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [1:0] status, [6:2] entry_count, [7] zero
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned EXT_W = (CNT_W > slid_pkg::COUNT_W) ? CNT_W : slid_pkg::COUNT_W;
    localparam int unsigned VW    = slid_pkg::VALUE_W;

    slid_pkg::t_state     r_state, n_state;
    slid_pkg::t_cell_ctrl w_ctrl;

    logic [VW-1:0]    r_key;
    logic             r_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    logic [slid_pkg::STATUS_W-1:0] r_status, n_status;
    logic [slid_pkg::COUNT_W-1:0]  r_out_count;
    logic [EXT_W-1:0] w_count_ext;

    logic          w_accept;
    logic          w_out_free;
    logic          w_apply;
    logic          w_full;
    logic          w_empty;
    logic          w_found;

    logic [VW-1:0]       w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_hit;

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_apply    = (r_state == slid_pkg::S_APPLY) && w_out_free;
    assign o_s_axis_tready = (r_state == slid_pkg::S_IDLE) || w_apply;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_found = |w_hit;

    // Sequence compare and shift, decide the outcome
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = slid_pkg::ST_DONE;
        w_ctrl   = '0;
        unique case (r_state)
            slid_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = slid_pkg::S_CMP;
                end
            end
            slid_pkg::S_CMP: begin
                w_ctrl.cmp_en = 1'b1;
                n_state       = slid_pkg::S_APPLY;
            end
            slid_pkg::S_APPLY: begin
                if (r_mode == slid_pkg::MODE_INSERT) begin
                    if (w_full) begin
                        n_status = slid_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end else begin
                    if (w_empty) begin
                        n_status = slid_pkg::ST_EMPTY;
                    end else if (!w_found) begin
                        n_status = slid_pkg::ST_NOT_FOUND;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                if (w_apply) begin
                    w_ctrl.apply_ins = (r_mode == slid_pkg::MODE_INSERT) && !w_full;
                    w_ctrl.apply_del = (r_mode == slid_pkg::MODE_DELETE) && !w_empty
                                       && w_found;
                    n_state = w_accept ? slid_pkg::S_CMP : slid_pkg::S_IDLE;
                end else begin
                    n_count = r_count;
                end
            end
            default: begin
                n_state = slid_pkg::S_IDLE;
            end
        endcase
    end

    // Hold state and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slid_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_apply) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the item and the result payload
    assign w_count_ext = EXT_W'(n_count);
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key  <= i_s_axis_tdata;
            r_mode <= i_s_axis_tuser[0];
        end
        if (w_apply) begin
            r_status    <= n_status;
            r_out_count <= w_count_ext[slid_pkg::COUNT_W-1:0];
        end
    end

    // Chain of cells, one per slot
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VW-1:0] w_left_entry;
        logic          w_left_lt;
        logic [VW-1:0] w_right_entry;

        if (g == 0) begin : g_first
            assign w_left_entry = r_key;
            assign w_left_lt    = 1'b1;
        end else begin : g_mid
            assign w_left_entry = w_entry[g-1];
            assign w_left_lt    = w_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right_entry = w_entry[g];
        end else begin : g_inner
            assign w_right_entry = w_entry[g+1];
        end

        slid_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_key         (r_key),
            .i_count       (r_count),
            .i_left_entry  (w_left_entry),
            .i_left_lt     (w_left_lt),
            .i_right_entry (w_right_entry),
            .o_entry       (w_entry[g]),
            .o_lt          (w_lt[g]),
            .o_hit         (w_hit[g])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_status};

endmodule
`default_nettype wire
